// ===== rtl/core/chte_pkg.sv =====
// Package with the request and result types and constants of the chained hash table engine.
package chte_pkg;

  localparam int unsigned MaxBuckets = 64;
  localparam int unsigned ChainDepth = 8;
  localparam int unsigned NameBytes  = 8;
  localparam int unsigned KeyW       = 34;
  localparam int unsigned NameW      = 64;
  localparam int unsigned BucketW    = $clog2(MaxBuckets);
  localparam int unsigned PosW       = $clog2(ChainDepth);
  localparam int unsigned CountW     = $clog2(ChainDepth + 1);
  localparam int unsigned SlotW      = BucketW + PosW;
  localparam int unsigned SizeW      = 7;

  localparam logic [2:0] ReqInsert = 3'd0;
  localparam logic [2:0] ReqDelete = 3'd1;
  localparam logic [2:0] ReqSearch = 3'd2;
  localparam logic [2:0] ReqList   = 3'd3;
  localparam logic [2:0] ReqClear  = 3'd4;

  localparam logic [2:0] StSuccess  = 3'd0;
  localparam logic [2:0] StFailure  = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StItem     = 3'd5;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [KeyW-1:0]  key;
    logic [NameW-1:0] caller_name;
    logic [5:0]       list_bucket;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [NameW-1:0] found_caller;
    logic [5:0]       bucket_index;
    logic [KeyW-1:0]  listed_key;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
    logic [SizeW-1:0] modulus;
  } mod_req_t;

  function automatic logic [NameW-1:0] name_mask();
    logic [NameW-1:0] m;
    m = '0;
    for (int i = 0; i < NameBytes; i++) m[i*8 +: 8] = 8'hFF;
    return m;
  endfunction

endpackage

// ===== rtl/core/chte_mod.sv =====
// Restoring serial divider that gives a key modulo the table size, one bit a cycle.
module chte_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chte_pkg::mod_req_t           req_i,
  output logic                         done_o,
  output logic [chte_pkg::SizeW-1:0]   rem_o
);

  localparam int unsigned CntW = $clog2(chte_pkg::KeyW + 1);

  logic [chte_pkg::KeyW-1:0]  shift_q, shift_d;
  logic [chte_pkg::SizeW:0]   rem_q, rem_d;
  logic [chte_pkg::SizeW-1:0] div_q, div_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [chte_pkg::SizeW:0]   trial;

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    trial   = {rem_q[chte_pkg::SizeW-1:0], shift_q[chte_pkg::KeyW-1]};
    if (req_i.start) begin
      shift_d = req_i.key;
      rem_d   = '0;
      div_d   = req_i.modulus;
      cnt_d   = CntW'(chte_pkg::KeyW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[chte_pkg::KeyW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[chte_pkg::SizeW-1:0];

endmodule

// ===== rtl/core/chained_hash_table_engine.sv =====
// Top level of the chained hash table engine with entry memories and request sequencer.
// Sequence: a key request runs the serial modulo, reads the bucket count, scans the chain
// entry by entry, shifts entries for an insert or delete and gives its result; a list reads
// the count and gives its keys in turn, held on a stall. One request is in flight at a time.
// Reset clears the bucket counts' valid bits and the control state at once and sets table_size
// to 64; the entry memories are not cleared and need no sweep.
module chained_hash_table_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  chte_pkg::req_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output chte_pkg::rsp_t       out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [6:0]           cfg_data_i
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SMod    = 4'd1;
  localparam logic [3:0] SRead   = 4'd2;
  localparam logic [3:0] SScan   = 4'd3;
  localparam logic [3:0] SShRd   = 4'd4;
  localparam logic [3:0] SShWr   = 4'd5;
  localparam logic [3:0] SFinish = 4'd6;
  localparam logic [3:0] SEmit   = 4'd7;
  localparam logic [3:0] SLRd    = 4'd8;
  localparam logic [3:0] SLWait  = 4'd9;
  localparam logic [3:0] SDone   = 4'd10;
  localparam logic [3:0] SCnt    = 4'd11;

  localparam int unsigned PosW   = chte_pkg::PosW;
  localparam int unsigned CountW = chte_pkg::CountW;
  localparam int unsigned SlotW  = chte_pkg::SlotW;
  localparam int unsigned BW     = chte_pkg::BucketW;
  localparam int unsigned SlotN  = chte_pkg::MaxBuckets * chte_pkg::ChainDepth;

  logic [chte_pkg::KeyW-1:0]  key_mem  [SlotN];
  logic [chte_pkg::NameW-1:0] name_mem [SlotN];
  logic [CountW-1:0]          cnt_mem  [chte_pkg::MaxBuckets];
  logic [chte_pkg::MaxBuckets-1:0] cvalid_q, cvalid_d;

  logic [3:0]                 state_q, state_d;
  logic [chte_pkg::SizeW-1:0] size_q;
  chte_pkg::req_t             req_q, req_d;
  logic [BW-1:0]              bucket_q, bucket_d;
  logic [CountW-1:0]          n_q, n_d;
  logic [PosW-1:0]            idx_q, idx_d;
  logic [CountW-1:0]          ci_q, ci_d;
  logic [CountW-1:0]          pos_q, pos_d;
  logic                       hit_q, hit_d;
  chte_pkg::rsp_t             out_q, out_d;
  logic                       ov_q, ov_d;

  logic                       mem_we;
  logic [SlotW-1:0]           mem_waddr, mem_raddr;
  logic [chte_pkg::KeyW-1:0]  mem_wkey, rd_key_q;
  logic [chte_pkg::NameW-1:0] mem_wname, rd_name_q;
  logic                       cnt_we;
  logic [BW-1:0]              cnt_addr;
  logic [CountW-1:0]          cnt_wdata, cnt_rd, cnt_rd_q;
  logic                       cval_rd_q;
  logic [chte_pkg::NameW-1:0] hold_name_q, hold_name_d;

  logic [chte_pkg::SizeW-1:0] eff_size;
  chte_pkg::mod_req_t         mod_req;
  logic                       mod_done;
  logic [chte_pkg::SizeW-1:0] mod_rem;
  logic                       accept;

  always_comb begin
    if (size_q == '0) begin
      eff_size = chte_pkg::SizeW'(1);
    end else if (size_q > chte_pkg::SizeW'(chte_pkg::MaxBuckets)) begin
      eff_size = chte_pkg::SizeW'(chte_pkg::MaxBuckets);
    end else begin
      eff_size = size_q;
    end
  end

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != SIdle) || ov_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  assign mod_req.start   = accept;
  assign mod_req.key     = in_data_i.key;
  assign mod_req.modulus = eff_size;

  chte_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  assign cnt_rd = cval_rd_q ? cnt_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_waddr]  <= mem_wkey;
      name_mem[mem_waddr] <= mem_wname;
    end
    rd_key_q  <= key_mem[mem_raddr];
    rd_name_q <= name_mem[mem_raddr];
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    cnt_rd_q  <= cnt_mem[cnt_addr];
    cval_rd_q <= cvalid_q[cnt_addr];
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    bucket_d    = bucket_q;
    n_d         = n_q;
    idx_d       = idx_q;
    ci_d        = ci_q;
    pos_d       = pos_q;
    hit_d       = hit_q;
    out_d       = out_q;
    ov_d        = ov_q;
    cvalid_d    = cvalid_q;
    hold_name_d = hold_name_q;
    mem_we      = 1'b0;
    mem_waddr   = {bucket_q, idx_q};
    mem_raddr   = {bucket_q, idx_q};
    mem_wkey    = req_q.key;
    mem_wname   = hold_name_q;
    cnt_we      = 1'b0;
    cnt_addr    = bucket_q;
    cnt_wdata   = n_q;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (state_q)
      SIdle: begin
        if (accept) begin
          req_d = in_data_i;
          out_d = '0;
          out_d.last = 1'b1;
          if (in_data_i.req_type == chte_pkg::ReqClear) begin
            cvalid_d = '0;
            out_d.status = chte_pkg::StSuccess;
            state_d = SDone;
          end else if (in_data_i.req_type == chte_pkg::ReqList) begin
            if ({1'b0, in_data_i.list_bucket} >= eff_size) begin
              state_d = SIdle;
            end else begin
              bucket_d = in_data_i.list_bucket[BW-1:0];
              cnt_addr = in_data_i.list_bucket[BW-1:0];
              state_d  = SCnt;
            end
          end else if (in_data_i.req_type inside {chte_pkg::ReqInsert, chte_pkg::ReqDelete,
                                                  chte_pkg::ReqSearch}) begin
            state_d = SMod;
          end else begin
            out_d.status = chte_pkg::StFailure;
            state_d = SDone;
          end
        end
      end
      SMod: begin
        if (mod_done) begin
          bucket_d = mod_rem[BW-1:0];
          cnt_addr = mod_rem[BW-1:0];
          out_d.bucket_index = 6'(mod_rem);
          idx_d    = '0;
          ci_d     = '0;
          hit_d    = 1'b0;
          state_d  = SCnt;
        end
      end
      SCnt: begin
        n_d = cnt_rd;
        if (req_q.req_type == chte_pkg::ReqList) begin
          ci_d    = '0;
          state_d = (cnt_rd == '0) ? SIdle : SLRd;
        end else begin
          pos_d   = cnt_rd;
          state_d = (cnt_rd == '0) ? SFinish : SRead;
        end
      end
      SRead: begin
        mem_raddr = {bucket_q, ci_q[PosW-1:0]};
        state_d   = SScan;
      end
      SScan: begin
        if (rd_key_q == req_q.key) begin
          hit_d   = 1'b1;
          pos_d   = ci_q;
          hold_name_d = rd_name_q;
          state_d = SFinish;
        end else begin
          if (rd_key_q > req_q.key && pos_q == n_q) pos_d = ci_q;
          ci_d = ci_q + 1'b1;
          state_d = (ci_q + 1'b1 == n_q) ? SFinish : SRead;
        end
      end
      SFinish: begin
        case (req_q.req_type)
          chte_pkg::ReqSearch: begin
            out_d.status = hit_q ? chte_pkg::StFound : chte_pkg::StNotFound;
            out_d.found_caller = hit_q ? hold_name_q : '0;
            state_d = SDone;
          end
          chte_pkg::ReqDelete: begin
            if (!hit_q) begin
              out_d.status = chte_pkg::StFailure;
              state_d = SDone;
            end else begin
              out_d.status = chte_pkg::StSuccess;
              cnt_we = 1'b1;
              cnt_wdata = n_q - 1'b1;
              cvalid_d[bucket_q] = 1'b1;
              ci_d = pos_q + 1'b1;
              state_d = (pos_q + 1'b1 >= n_q) ? SDone : SShRd;
            end
          end
          default: begin
            if (hit_q) begin
              out_d.status = chte_pkg::StFailure;
              state_d = SDone;
            end else if (n_q >= CountW'(chte_pkg::ChainDepth)) begin
              out_d.status = chte_pkg::StFull;
              state_d = SDone;
            end else begin
              out_d.status = chte_pkg::StSuccess;
              cnt_we = 1'b1;
              cnt_wdata = n_q + 1'b1;
              cvalid_d[bucket_q] = 1'b1;
              ci_d = n_q;
              state_d = SShRd;
            end
          end
        endcase
      end
      SShRd: begin
        if (req_q.req_type == chte_pkg::ReqDelete) begin
          mem_raddr = {bucket_q, ci_q[PosW-1:0]};
          state_d = SShWr;
        end else if (ci_q == pos_q) begin
          mem_we    = 1'b1;
          mem_waddr = {bucket_q, pos_q[PosW-1:0]};
          mem_wkey  = req_q.key;
          mem_wname = req_q.caller_name & chte_pkg::name_mask();
          state_d   = SDone;
        end else begin
          mem_raddr = {bucket_q, PosW'(ci_q - 1'b1)};
          state_d = SShWr;
        end
      end
      SShWr: begin
        mem_we    = 1'b1;
        mem_wkey  = rd_key_q;
        mem_wname = rd_name_q;
        if (req_q.req_type == chte_pkg::ReqDelete) begin
          mem_waddr = {bucket_q, PosW'(ci_q - 1'b1)};
          ci_d = ci_q + 1'b1;
          state_d = (ci_q + 1'b1 >= n_q) ? SDone : SShRd;
        end else begin
          mem_waddr = {bucket_q, ci_q[PosW-1:0]};
          ci_d = ci_q - 1'b1;
          state_d = SShRd;
        end
      end
      SLRd: begin
        if (!ov_q || !out_stall_i) begin
          mem_raddr = {bucket_q, ci_q[PosW-1:0]};
          state_d = SLWait;
        end
      end
      SLWait: begin
        if (!ov_d) begin
          out_d = '0;
          out_d.status = chte_pkg::StItem;
          out_d.bucket_index = 6'(bucket_q);
          out_d.listed_key = rd_key_q;
          out_d.last = (ci_q + 1'b1 == n_q);
          ov_d = 1'b1;
          ci_d = ci_q + 1'b1;
          state_d = (ci_q + 1'b1 == n_q) ? SIdle : SLRd;
        end
      end
      SDone: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      size_q   <= chte_pkg::SizeW'(chte_pkg::MaxBuckets);
      cvalid_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cvalid_q <= cvalid_d;
      ov_q     <= ov_d;
      if (cfg_valid_i && cfg_ready_o) size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    bucket_q    <= bucket_d;
    n_q         <= n_d;
    idx_q       <= idx_d;
    ci_q        <= ci_d;
    pos_q       <= pos_d;
    hit_q       <= hit_d;
    out_q       <= out_d;
    hold_name_q <= hold_name_d;
  end

endmodule
